// ===== rtl/core/plc_pkg.sv =====
package plc_pkg;

   localparam int unsigned ScreenWidth  = 240;
   localparam int unsigned ScreenHeight = 160;

   // configuration register indexes
   localparam logic [2:0] REG_DISPLAY_CTRL = 3'd0;
   localparam logic [2:0] REG_WIN0         = 3'd1;
   localparam logic [2:0] REG_WIN1         = 3'd2;
   localparam logic [2:0] REG_WIN_INSIDE   = 3'd3;
   localparam logic [2:0] REG_WIN_OUTSIDE  = 3'd4;
   localparam logic [2:0] REG_BLEND_CTRL   = 3'd5;
   localparam logic [2:0] REG_BLEND_ALPHA  = 3'd6;
   localparam logic [2:0] REG_BRIGHTNESS   = 3'd7;

   // effect kinds
   localparam logic [1:0] EFF_NONE    = 2'd0;
   localparam logic [1:0] EFF_BLEND   = 2'd1;
   localparam logic [1:0] EFF_LIGHTEN = 2'd2;
   localparam logic [1:0] EFF_DARKEN  = 2'd3;

   localparam logic [5:0] KEY_NONE = 6'h3F;

   // stage 1 to stage 2: the two top layers
   typedef struct packed {
      logic        blank;
      logic        effect_on;
      logic [5:0]  k1;
      logic [5:0]  k2;
      logic [14:0] c1;
      logic [14:0] c2;
      logic [5:0]  l1;
      logic [5:0]  l2;
   } rank_type;

   function automatic logic [4:0] clamp16(input logic [4:0] v);
      clamp16 = (v > 5'd16) ? 5'd16 : v;
   endfunction

   // c*255/31 for a 5-bit channel; divide by 31 as multiply by 2^20/31 rounded up
   function automatic logic [7:0] widen5(input logic [4:0] c);
      logic [12:0] p;
      logic [28:0] q;
      p = {8'd0, c} * 13'd255;
      q = 29'(p) * 29'd33826;
      widen5 = q[27:20];
   endfunction

endpackage

// ===== rtl/core/plc_rank.sv =====
module plc_rank (
   input  logic                  clock,
   input  logic [15:0]           dispcnt,
   input  logic [31:0]           win0,
   input  logic [31:0]           win1,
   input  logic [15:0]           winin,
   input  logic [15:0]           winout,
   input  logic [7:0]            pixel_x,
   input  logic [7:0]            pixel_y,
   input  logic [59:0]           bg_colors,
   input  logic [3:0]            bg_opaque,
   input  logic [7:0]            bg_priorities,
   input  logic [14:0]           obj_color,
   input  logic                  obj_opaque,
   input  logic [1:0]            obj_priority,
   input  logic                  obj_window_hit,
   input  logic [14:0]           backdrop_color,
   output plc_pkg::rank_type     rank
);
   import plc_pkg::*;

   function automatic logic in_range(input logic [7:0] c, input logic [8:0] lim,
                                     input logic [15:0] r);
      logic [8:0] s;
      logic [8:0] e;
      s = {1'b0, r[15:8]};
      e = {1'b0, r[7:0]};
      if (s >= lim) s = lim - 9'd1;
      if (e >= lim) e = lim;
      if (s <= e) in_range = ({1'b0, c} >= s) && ({1'b0, c} < e);
      else        in_range = ({1'b0, c} >= s) || ({1'b0, c} < e);
   endfunction

   logic       in0, in1;
   logic [5:0] ctl;
   logic [4:0] visible;
   logic       eff_on;
   logic [2:0] mode;
   logic [5:0] key [6];
   logic [14:0] col [6];
   logic [5:0] ok;
   logic [5:0] k1, k2, l1, l2;
   logic [14:0] c1, c2;
   rank_type   rank_in;

   always_comb begin
      mode = dispcnt[2:0];
      in0 = in_range(pixel_x, 9'(ScreenWidth), win0[15:0]) &&
            in_range(pixel_y, 9'(ScreenHeight), win0[31:16]);
      in1 = in_range(pixel_x, 9'(ScreenWidth), win1[15:0]) &&
            in_range(pixel_y, 9'(ScreenHeight), win1[31:16]);
      // window region select
      if (dispcnt[13] && in0)                        ctl = winin[5:0];
      else if (dispcnt[14] && in1)                   ctl = winin[13:8];
      else if (dispcnt[15] && dispcnt[12] && obj_window_hit) ctl = winout[13:8];
      else                                           ctl = winout[5:0];
      if (dispcnt[15:13] != 3'd0) begin
         visible = ctl[4:0];
         eff_on  = ctl[5];
      end else begin
         visible = 5'h1F;
         eff_on  = 1'b1;
      end
      // candidate keys
      for (int n = 0; n < 4; n++) begin
         ok[n] = ((mode == 3'd0) || (mode == 3'd1 && n < 3) || (mode == 3'd2 && n >= 2))
                 && visible[n] && dispcnt[8+n] && bg_opaque[n];
         key[n] = {1'b0, bg_priorities[2*n +: 2], 1'b1, 2'(n)};
         col[n] = bg_colors[15*n +: 15];
      end
      ok[4]  = obj_opaque && dispcnt[12] && visible[4];
      key[4] = {1'b0, obj_priority, 3'd0};
      col[4] = obj_color;
      ok[5]  = 1'b1;
      key[5] = 6'd32;
      col[5] = backdrop_color;
      // keep the best two
      k1 = KEY_NONE; k2 = KEY_NONE; c1 = '0; c2 = '0; l1 = '0; l2 = '0;
      for (int n = 0; n < 6; n++) begin
         if (ok[n]) begin
            if (key[n] < k1) begin
               k2 = k1; c2 = c1; l2 = l1;
               k1 = key[n]; c1 = col[n]; l1 = 6'(1 << n);
            end else if (key[n] < k2) begin
               k2 = key[n]; c2 = col[n]; l2 = 6'(1 << n);
            end
         end
      end
      rank_in.blank     = dispcnt[7];
      rank_in.effect_on = eff_on;
      rank_in.k1 = k1; rank_in.k2 = k2;
      rank_in.c1 = c1; rank_in.c2 = c2;
      rank_in.l1 = l1; rank_in.l2 = l2;
   end

   always_ff @(posedge clock) begin
      rank <= rank_in;
   end

endmodule

// ===== rtl/core/pixel_layer_compositor.sv =====
// Pixel layer compositor.
// Request channel (req_*): one pixel with its background, sprite and
// backdrop samples per request, taken when req_valid is high and
// req_stall low. Response channel (rsp_*): one RGBA8888 pixel per
// request, in order.
// Pipeline: rank stage, effect stage, widen stage, then the output
// register; rsp_valid follows each accepted request down the stages.
// Throughput is one pixel per clock unless the output is stalled;
// every stage is a single register. rsp_stall with rsp_valid high
// freezes the whole pipeline; req_stall rises only while the output
// register holds an untaken pixel, so nothing is lost or repeated.
// Configuration is written through csr_write/csr_index/csr_data; the
// user must write it only while the pipeline is empty; not enforced.
// Sync active-high reset zeroes configuration registers and valid bits.
module pixel_layer_compositor (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   input  logic [59:0] req_bg_colors,
   input  logic [3:0]  req_bg_opaque,
   input  logic [7:0]  req_bg_priorities,
   input  logic [14:0] req_obj_color,
   input  logic        req_obj_opaque,
   input  logic [1:0]  req_obj_priority,
   input  logic        req_obj_window_hit,
   input  logic [14:0] req_backdrop_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_rgba_pixel
);
   import plc_pkg::*;

   logic [15:0] dispcnt_ff, winin_ff, winout_ff, bldcnt_ff, bldalpha_ff;
   logic [31:0] win0_ff, win1_ff;
   logic [4:0]  bldy_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dispcnt_ff <= '0; win0_ff <= '0; win1_ff <= '0; winin_ff <= '0;
         winout_ff <= '0; bldcnt_ff <= '0; bldalpha_ff <= '0; bldy_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_DISPLAY_CTRL: dispcnt_ff  <= csr_data[15:0];
            REG_WIN0:         win0_ff     <= csr_data;
            REG_WIN1:         win1_ff     <= csr_data;
            REG_WIN_INSIDE:   winin_ff    <= csr_data[15:0];
            REG_WIN_OUTSIDE:  winout_ff   <= csr_data[15:0];
            REG_BLEND_CTRL:   bldcnt_ff   <= csr_data[15:0];
            REG_BLEND_ALPHA:  bldalpha_ff <= csr_data[15:0];
            REG_BRIGHTNESS:   bldy_ff     <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless the output holds an untaken pixel
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   rank_type rank_q, rank_ff;

   plc_rank u_rank (
      .clock          (clock),
      .dispcnt        (dispcnt_ff),
      .win0           (win0_ff),
      .win1           (win1_ff),
      .winin          (winin_ff),
      .winout         (winout_ff),
      .pixel_x        (req_pixel_x),
      .pixel_y        (req_pixel_y),
      .bg_colors      (req_bg_colors),
      .bg_opaque      (req_bg_opaque),
      .bg_priorities  (req_bg_priorities),
      .obj_color      (req_obj_color),
      .obj_opaque     (req_obj_opaque),
      .obj_priority   (req_obj_priority),
      .obj_window_hit (req_obj_window_hit),
      .backdrop_color (req_backdrop_color),
      .rank           (rank_q)
   );

   // rank output is registered inside plc_rank on every clock; hold a copy
   // so a stall does not lose it
   logic     hold_ff;
   always_ff @(posedge clock) begin
      hold_ff <= advance;
      if (hold_ff) rank_ff <= rank_q;
   end
   rank_type rank_s;
   assign rank_s = hold_ff ? rank_q : rank_ff;

   // effect stage
   logic [4:0]  eva, evb, ky;
   logic [14:0] color;
   logic [9:0]  mix;
   logic [4:0]  a, b;
   logic [14:0] color_ff;
   logic        blank2_ff;

   always_comb begin
      eva = clamp16(bldalpha_ff[4:0]);
      evb = clamp16(bldalpha_ff[12:8]);
      ky  = clamp16(bldy_ff);
      color = rank_s.c1;
      mix = '0;
      a = '0;
      b = '0;
      if (rank_s.effect_on && ((rank_s.l1 & bldcnt_ff[5:0]) != 6'd0)) begin
         case (bldcnt_ff[7:6])
            EFF_BLEND: begin
               if (rank_s.k2 != KEY_NONE && ((rank_s.l2 & bldcnt_ff[13:8]) != 6'd0)) begin
                  for (int i = 0; i < 3; i++) begin
                     a = rank_s.c1[5*i +: 5];
                     b = rank_s.c2[5*i +: 5];
                     mix = (10'(a) * 10'(eva) + 10'(b) * 10'(evb)) >> 4;
                     color[5*i +: 5] = (mix > 10'd31) ? 5'd31 : mix[4:0];
                  end
               end
            end
            EFF_LIGHTEN: begin
               for (int i = 0; i < 3; i++) begin
                  a = rank_s.c1[5*i +: 5];
                  mix = (10'(5'd31 - a) * 10'(ky)) >> 4;
                  color[5*i +: 5] = a + mix[4:0];
               end
            end
            EFF_DARKEN: begin
               for (int i = 0; i < 3; i++) begin
                  a = rank_s.c1[5*i +: 5];
                  mix = (10'(a) * 10'(ky)) >> 4;
                  color[5*i +: 5] = a - mix[4:0];
               end
            end
            default: ;
         endcase
      end
   end

   // widen stage
   logic [31:0] pix_ff, out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (advance) begin
         color_ff  <= color;
         blank2_ff <= rank_s.blank;
         pix_ff    <= blank2_ff ? 32'hFFFF_FFFF :
                      {8'hFF, widen5(color_ff[14:10]), widen5(color_ff[9:5]),
                       widen5(color_ff[4:0])};
         out_ff    <= pix_ff;
      end
   end

   assign rsp_valid      = v4_ff;
   assign rsp_rgba_pixel = out_ff;

endmodule

// ===== sim/tb.sv =====
module tb;
   import plc_pkg::*;

   // compositor register copy, kept in step with the csr writes
   logic [15:0] dispcnt_q, winin_q, winout_q, bldcnt_q, bldalpha_q;
   logic [31:0] win0_q, win1_q;
   logic [4:0]  bldy_q;

   // expected pixels in acceptance order, and mismatch reporting
   class pixel_scoreboard;
      logic [31:0] pending_pixels[$];
      int errors;
      int matched;

      function void note_request(logic [31:0] rgba);
         pending_pixels.push_back(rgba);
      endfunction

      function void check_response(logic [31:0] got);
         logic [31:0] want;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, got %h", $time, got);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (want !== got) begin
               $display("%0t: rgba_pixel expected %h got %h", $time, want, got);
               errors++;
            end else begin
               matched++;
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [2:0]  csr_index = REG_DISPLAY_CTRL;
   logic [31:0] csr_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_pixel_x = 0, req_pixel_y = 0;
   logic [59:0] req_bg_colors = 0;
   logic [3:0]  req_bg_opaque = 0;
   logic [7:0]  req_bg_priorities = 0;
   logic [14:0] req_obj_color = 0;
   logic        req_obj_opaque = 0;
   logic [1:0]  req_obj_priority = 0;
   logic        req_obj_window_hit = 0;
   logic [14:0] req_backdrop_color = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_rgba_pixel;

   pixel_scoreboard board;
   int idle_cycles;
   int long_hold;
   int sent;
   bit stall_random;

   pixel_layer_compositor dut (.*);

   always #1 clock = ~clock;

   // one request as the block sees it
   typedef struct {
      logic [7:0]  x, y;
      logic [59:0] bgc;
      logic [3:0]  bgo;
      logic [7:0]  bgp;
      logic [14:0] objc;
      logic        objo;
      logic [1:0]  objp;
      logic        objw;
      logic [14:0] back;
   } pixel_req_type;

   function automatic logic [4:0] sat16(logic [4:0] v);
      return (v > 5'd16) ? 5'd16 : v;
   endfunction

   function automatic bit coord_in_span(logic [7:0] c, int lim, logic [15:0] span);
      int s, e;
      s = span[15:8];
      e = span[7:0];
      if (s >= lim) s = lim - 1;
      if (e >= lim) e = lim;
      if (s <= e) return (c >= s) && (c < e);
      return (c >= s) || (c < e);
   endfunction

   function automatic bit pixel_in_window(logic [7:0] x, logic [7:0] y, logic [31:0] b);
      return coord_in_span(x, ScreenWidth, b[15:0]) &&
             coord_in_span(y, ScreenHeight, b[31:16]);
   endfunction

   function automatic logic [31:0] expand_rgb555(logic [14:0] c);
      logic [31:0] o;
      o = 32'hFF000000;
      for (int i = 0; i < 3; i++) o[8*i +: 8] = 8'((int'(c[5*i +: 5]) * 255) / 31);
      return o;
   endfunction

   // composite one pixel under the current register copy
   function automatic logic [31:0] composite_pixel(pixel_req_type p);
      logic [5:0]  ctl;
      logic [4:0]  vis;
      bit          eff_on;
      int          k1, k2, key;
      logic [14:0] c1, c2, col, res;
      logic [5:0]  l1, l2, lay;
      logic [2:0]  mode;
      bit          ok;
      int          v, k, eva, evb;
      if (dispcnt_q[7]) return 32'hFFFFFFFF;
      mode = dispcnt_q[2:0];
      vis = 5'h1F;
      eff_on = 1;
      k1 = 255; k2 = 255; c1 = 0; c2 = 0; l1 = 0; l2 = 0;
      if (dispcnt_q[15:13] != 0) begin
         if (dispcnt_q[13] && pixel_in_window(p.x, p.y, win0_q)) ctl = winin_q[5:0];
         else if (dispcnt_q[14] && pixel_in_window(p.x, p.y, win1_q)) ctl = winin_q[13:8];
         else if (dispcnt_q[15] && dispcnt_q[12] && p.objw) ctl = winout_q[13:8];
         else ctl = winout_q[5:0];
         vis = ctl[4:0];
         eff_on = ctl[5];
      end
      for (int n = 0; n < 6; n++) begin
         lay = 6'(1 << n);
         if (n < 4) begin
            ok = (mode == 0) || (mode == 1 && n < 3) || (mode == 2 && n >= 2);
            if (!ok || !vis[n] || !dispcnt_q[8+n] || !p.bgo[n]) continue;
            key = (int'(p.bgp[2*n +: 2]) << 3) | 4 | n;
            col = p.bgc[15*n +: 15];
         end else if (n == 4) begin
            if (!p.objo || !dispcnt_q[12] || !vis[4]) continue;
            key = int'(p.objp) << 3;
            col = p.objc;
         end else begin
            key = 32;
            col = p.back;
         end
         if (key < k1) begin
            k2 = k1; c2 = c1; l2 = l1;
            k1 = key; c1 = col; l1 = lay;
         end else if (key < k2) begin
            k2 = key; c2 = col; l2 = lay;
         end
      end
      res = c1;
      if (eff_on && (l1 & bldcnt_q[5:0]) != 0) begin
         k = sat16(bldy_q);
         eva = sat16(bldalpha_q[4:0]);
         evb = sat16(bldalpha_q[12:8]);
         case (bldcnt_q[7:6])
            EFF_BLEND: begin
               if (k2 != 255 && (l2 & bldcnt_q[13:8]) != 0)
                  for (int i = 0; i < 3; i++) begin
                     v = (int'(c1[5*i +: 5]) * eva + int'(c2[5*i +: 5]) * evb) / 16;
                     res[5*i +: 5] = (v > 31) ? 5'd31 : 5'(v);
                  end
            end
            EFF_LIGHTEN: begin
               for (int i = 0; i < 3; i++) begin
                  v = c1[5*i +: 5];
                  res[5*i +: 5] = 5'(v + ((31 - v) * k) / 16);
               end
            end
            EFF_DARKEN: begin
               for (int i = 0; i < 3; i++) begin
                  v = c1[5*i +: 5];
                  res[5*i +: 5] = 5'(v - (v * k) / 16);
               end
            end
            default: ;
         endcase
      end
      return expand_rgb555(res);
   endfunction

   // one register write, then csr_write low on the port before returning
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         REG_DISPLAY_CTRL: dispcnt_q = val[15:0];
         REG_WIN0:         win0_q = val;
         REG_WIN1:         win1_q = val;
         REG_WIN_INSIDE:   winin_q = val[15:0];
         REG_WIN_OUTSIDE:  winout_q = val[15:0];
         REG_BLEND_CTRL:   bldcnt_q = val[15:0];
         REG_BLEND_ALPHA:  bldalpha_q = val[15:0];
         default:          bldy_q = val[4:0];
      endcase
      @(negedge clock);
   endtask

   // offer one request and hold it until taken; optional gap first
   task automatic send_pixel(pixel_req_type p, bit with_gap);
      int gap;
      gap = with_gap ? $urandom_range(0, 11) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_pixel_x <= p.x;
      req_pixel_y <= p.y;
      req_bg_colors <= p.bgc;
      req_bg_opaque <= p.bgo;
      req_bg_priorities <= p.bgp;
      req_obj_color <= p.objc;
      req_obj_opaque <= p.objo;
      req_obj_priority <= p.objp;
      req_obj_window_hit <= p.objw;
      req_backdrop_color <= p.back;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      board.note_request(composite_pixel(p));
      sent++;
      idle_cycles = 0;
      @(negedge clock);
   endtask

   function automatic pixel_req_type random_pixel();
      pixel_req_type p;
      p.x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 239));
      p.y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 159));
      p.bgc = 60'({$urandom, $urandom});
      p.bgo = 4'($urandom);
      p.bgp = 8'($urandom);
      p.objc = 15'($urandom);
      p.objo = 1'($urandom);
      p.objp = 2'($urandom);
      p.objw = 1'($urandom);
      p.back = 15'($urandom);
      return p;
   endfunction

   task automatic drain();
      req_valid <= 0;
      while (board.pending_pixels.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // random register setting, biased toward useful windows and effects
   task automatic random_setup(int phase);
      logic [31:0] w;
      write_reg(REG_DISPLAY_CTRL, (phase % 5 == 0) ? 32'h0000FF00 | $urandom_range(0, 7)
                                  : $urandom & 32'hFF7F);
      w = $urandom;
      if (phase % 3 == 0) w = {8'($urandom_range(0, 80)), 8'($urandom_range(60, 170)),
                               8'($urandom_range(0, 120)), 8'($urandom_range(100, 255))};
      write_reg(REG_WIN0, w);
      write_reg(REG_WIN1, $urandom);
      write_reg(REG_WIN_INSIDE, $urandom);
      write_reg(REG_WIN_OUTSIDE, $urandom);
      write_reg(REG_BLEND_CTRL, $urandom);
      write_reg(REG_BLEND_ALPHA, (phase % 4 == 0) ? 32'h1F1F : $urandom);
      write_reg(REG_BRIGHTNESS, (phase % 4 == 1) ? 31 : $urandom_range(0, 31));
   endtask

   // receiver: random stall per response, one long hold-off
   initial begin
      int wait_n;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_stall <= 1;
            repeat (long_hold) @(negedge clock);
            long_hold = 0;
            rsp_stall <= 0;
         end else if (stall_random && rsp_valid) begin
            wait_n = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) wait_n = 0;
            if (wait_n != 0) begin
               rsp_stall <= 1;
               repeat (wait_n) @(negedge clock);
               rsp_stall <= 0;
            end
            // this response is taken at the next edge
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_response(rsp_rgba_pixel);
         idle_cycles = 0;
      end
   end

   // watchdog on cycles with no progress
   always @(posedge clock) begin
      idle_cycles++;
      if (idle_cycles > 5000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      pixel_req_type p;
      board = new();
      {dispcnt_q, winin_q, winout_q, bldcnt_q, bldalpha_q} = 0;
      {win0_q, win1_q} = 0;
      bldy_q = 0;
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: reset config, extremes of every field
      p = random_pixel();
      p.bgc = 0; p.bgo = 0; p.bgp = 0; p.objc = 0; p.objo = 0;
      p.objp = 0; p.objw = 0; p.back = 0; p.x = 0; p.y = 0;
      send_pixel(p, 0);
      p.bgc = '1; p.bgo = '1; p.bgp = '1; p.objc = '1; p.objo = 1;
      p.objp = 3; p.objw = 1; p.back = '1; p.x = 255; p.y = 255;
      send_pixel(p, 0);
      drain();
      // forced blank
      write_reg(REG_DISPLAY_CTRL, 32'h0080);
      send_pixel(random_pixel(), 0);
      drain();
      // each effect, all layers on, no windows, saturating coefficients
      write_reg(REG_DISPLAY_CTRL, 32'h1F00);
      write_reg(REG_BLEND_ALPHA, 32'h1F1F);
      write_reg(REG_BRIGHTNESS, 31);
      for (int e = 0; e < 4; e++) begin
         write_reg(REG_BLEND_CTRL, 32'h3F3F | (e << 6));
         for (int i = 0; i < 3; i++) send_pixel(random_pixel(), 0);
         drain();
      end
      // every mode, windows with wrapped and oversized bounds, object window
      write_reg(REG_WIN0, 32'hF0109020);
      write_reg(REG_WIN1, 32'hFFFFFFFF);
      write_reg(REG_WIN_INSIDE, 32'h2A15);
      write_reg(REG_WIN_OUTSIDE, 32'h3F0C);
      for (int m = 0; m < 8; m++) begin
         write_reg(REG_DISPLAY_CTRL, 32'hFF00 | m);
         for (int i = 0; i < 2; i++) send_pixel(random_pixel(), 0);
         drain();
      end

      // random phases with random gaps and stalls
      stall_random = 1;
      for (int ph = 0; ph < 25; ph++) begin
         random_setup(ph);
         for (int i = 0; i < 68; i++) send_pixel(random_pixel(), ph % 6 != 2);
         if (ph == 10) begin
            long_hold = 300;
            for (int i = 0; i < 20; i++) send_pixel(random_pixel(), 0);
         end
         drain();
      end

      drain();
      $display("Sent %0d pixels over 25 random register settings plus directed modes,",
               sent);
      $display("windows and effects; %0d pixels matched.", board.matched);
      if (board.errors == 0 && board.pending_pixels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/plc_pkg.sv
rtl/core/plc_rank.sv
rtl/core/pixel_layer_compositor.sv
sim/tb.sv
